// ===== rtl/dsbmm_pkg.sv =====
// Package for the delay-and-sum binaural mono mixer: sizes, tap entry type, codes.
package dsbmm_pkg;

  // Storage sizes
  localparam int MAX_DELAY    = 1024;
  localparam int MAX_CHANNELS = 16;
  localparam int MAX_TAPS     = 32;

  // Fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int SLOT_W    = 5;
  localparam int SRC_W     = 4;
  localparam int DELAY_W   = 10;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 14;
  localparam int CPF_W     = 5;
  localparam int TC_W      = 6;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // Derived sizes
  localparam int FP_W       = $clog2(MAX_DELAY);
  localparam int CH_W       = $clog2(MAX_CHANNELS);
  localparam int HIST_AW    = FP_W + CH_W;
  localparam int HIST_DEPTH = 1 << HIST_AW;
  localparam int TAP_AW     = $clog2(MAX_TAPS);
  localparam int TAP_NW     = $clog2(MAX_TAPS + 1);
  localparam int CNT_W      = CPF_W + 1;
  localparam int DC_W       = ((FP_W > DELAY_W) ? FP_W : DELAY_W) + 1;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int SC_W       = PROD_W - GAIN_FRAC;
  localparam int ACC_W      = SC_W + TAP_NW;

  typedef struct packed {
    logic [SRC_W-1:0]   source;
    logic               ear;
    logic [DELAY_W-1:0] delay;
    logic [GAIN_W-1:0]  gain;
  } tap_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_LOAD   = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_CHANNELS = 1'b0,
    REG_TAPS     = 1'b1
  } reg_t;

  typedef enum logic {
    EAR_LEFT  = 1'b0,
    EAR_RIGHT = 1'b1
  } ear_t;

endpackage

// ===== rtl/delay_sum_binaural_mono_mixer.sv =====
// Delay-and-sum binaural mono mixer: history memory, tap table and tap walk sequencer.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------------
//  in      | in_valid / in_stall   | command, sample, tap_slot, tap_source,
//          |                       | tap_ear, tap_delay, tap_gain
//  out     | out_valid / out_stall | mono_sample
//  apb     | psel/penable/pready   | paddr, pwrite, pwdata, prdata
//
// A load transfer or a sample that does not close a frame is taken without stalling the input.
// A frame-closing sample stalls the input after its transfer while N taps (N = tap_count
// clamped to 32; none when N is 0) are issued into a four-stage pipeline (tap read,
// history read, multiply, accumulate); the pipeline then drains and the result is posted.
// The post cycle waits while the previous result is still stalled at the output.
// After reset a clearing pass zeroes all 16384 history entries, one per cycle;
// no input transfer is taken during it, configuration writes are.
// A result waiting on out_stall does not block samples that close no frame.
module delay_sum_binaural_mono_mixer (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [dsbmm_pkg::PADDR_W-1:0]           paddr,
  input  logic [dsbmm_pkg::PDATA_W-1:0]           pwdata,
  output logic [dsbmm_pkg::PDATA_W-1:0]           prdata,
  output logic                                    pready,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    command,
  input  logic signed [dsbmm_pkg::SAMPLE_W-1:0]   sample,
  input  logic [dsbmm_pkg::SLOT_W-1:0]            tap_slot,
  input  logic [dsbmm_pkg::SRC_W-1:0]             tap_source,
  input  logic                                    tap_ear,
  input  logic [dsbmm_pkg::DELAY_W-1:0]           tap_delay,
  input  logic [dsbmm_pkg::GAIN_W-1:0]            tap_gain,
  // output channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [dsbmm_pkg::SAMPLE_W-1:0]   mono_sample
);

  localparam logic signed [dsbmm_pkg::ACC_W-1:0] SAT_HI = dsbmm_pkg::ACC_W'(32767);
  localparam logic signed [dsbmm_pkg::ACC_W-1:0] SAT_LO = dsbmm_pkg::ACC_W'(-32768);
  localparam logic signed [dsbmm_pkg::PROD_W-1:0] TRUNC_BIAS =
    dsbmm_pkg::PROD_W'((1 << dsbmm_pkg::GAIN_FRAC) - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [dsbmm_pkg::CPF_W-1:0] channels_per_frame;
  logic [dsbmm_pkg::TC_W-1:0]  tap_count;
  logic                        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_per_frame <= dsbmm_pkg::CPF_W'(2);
      tap_count          <= '0;
    end else if (cfg_we) begin
      unique case (dsbmm_pkg::reg_t'(paddr[2]))
        dsbmm_pkg::REG_CHANNELS: channels_per_frame <= pwdata[dsbmm_pkg::CPF_W-1:0];
        dsbmm_pkg::REG_TAPS:     tap_count          <= pwdata[dsbmm_pkg::TC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (dsbmm_pkg::reg_t'(paddr[2]))
      dsbmm_pkg::REG_CHANNELS: prdata = dsbmm_pkg::PDATA_W'(channels_per_frame);
      dsbmm_pkg::REG_TAPS:     prdata = dsbmm_pkg::PDATA_W'(tap_count);
      default:                 prdata = '0;
    endcase
  end

  // Clamped frame width and tap count
  logic [dsbmm_pkg::CPF_W-1:0]  ch_eff;
  logic [dsbmm_pkg::TAP_NW-1:0] n_eff;

  always_comb begin
    if (int'(channels_per_frame) < 2) begin
      ch_eff = dsbmm_pkg::CPF_W'(2);
    end else if (int'(channels_per_frame) > dsbmm_pkg::MAX_CHANNELS) begin
      ch_eff = dsbmm_pkg::CPF_W'(dsbmm_pkg::MAX_CHANNELS);
    end else begin
      ch_eff = channels_per_frame;
    end
    if (int'(tap_count) > dsbmm_pkg::MAX_TAPS) begin
      n_eff = dsbmm_pkg::TAP_NW'(dsbmm_pkg::MAX_TAPS);
    end else begin
      n_eff = dsbmm_pkg::TAP_NW'(tap_count);
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  dsbmm_pkg::state_t            state, state_next;
  logic [dsbmm_pkg::HIST_AW-1:0] clear_addr;
  logic [dsbmm_pkg::FP_W-1:0]    frame_pointer;
  logic [dsbmm_pkg::CH_W-1:0]    channel_position;
  logic [dsbmm_pkg::TAP_NW-1:0]  issue_idx;
  logic                          s1_v, s2_v, s3_v;

  logic in_take, is_load, sample_take, load_take, frame_end, issue_more, out_free;

  assign in_take     = in_valid && !in_stall;
  assign is_load     = (dsbmm_pkg::cmd_t'(command) == dsbmm_pkg::CMD_LOAD);
  assign sample_take = in_take && !is_load;
  assign load_take   = in_take && is_load;
  assign frame_end   = (dsbmm_pkg::CNT_W'(channel_position) + dsbmm_pkg::CNT_W'(1))
                       >= dsbmm_pkg::CNT_W'(ch_eff);
  assign issue_more  = issue_idx < n_eff;
  assign out_free    = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dsbmm_pkg::ST_CLEAR: begin
        if (clear_addr == '1) state_next = dsbmm_pkg::ST_IDLE;
      end
      dsbmm_pkg::ST_IDLE: begin
        if (sample_take && frame_end) begin
          state_next = (n_eff == '0) ? dsbmm_pkg::ST_DONE : dsbmm_pkg::ST_WALK;
        end
      end
      dsbmm_pkg::ST_WALK: begin
        if (!issue_more && !s1_v && !s2_v && !s3_v) state_next = dsbmm_pkg::ST_DONE;
      end
      dsbmm_pkg::ST_DONE: begin
        if (out_free) state_next = dsbmm_pkg::ST_IDLE;
      end
      default: state_next = dsbmm_pkg::ST_CLEAR;
    endcase
  end

  // state outputs
  logic                          hist_we;
  logic [dsbmm_pkg::HIST_AW-1:0] hist_waddr;
  logic [dsbmm_pkg::SAMPLE_W-1:0] hist_wdata;
  logic                          walk_issue;
  logic                          post;

  always_comb begin
    in_stall   = 1'b1;
    hist_we    = 1'b0;
    hist_waddr = clear_addr;
    hist_wdata = '0;
    walk_issue = 1'b0;
    post       = 1'b0;
    unique case (state)
      dsbmm_pkg::ST_CLEAR: begin
        hist_we = 1'b1;
      end
      dsbmm_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        hist_we    = sample_take;
        hist_waddr = {frame_pointer, channel_position};
        hist_wdata = sample;
      end
      dsbmm_pkg::ST_WALK: begin
        walk_issue = issue_more;
      end
      dsbmm_pkg::ST_DONE: begin
        post = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= dsbmm_pkg::ST_CLEAR;
      clear_addr       <= '0;
      frame_pointer    <= '0;
      channel_position <= '0;
      issue_idx        <= '0;
      s1_v             <= 1'b0;
      s2_v             <= 1'b0;
      s3_v             <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dsbmm_pkg::ST_CLEAR) clear_addr <= clear_addr + 1'b1;
      if (sample_take) begin
        channel_position <= frame_end ? '0 : channel_position + 1'b1;
      end
      if (post) begin
        frame_pointer <= (int'(frame_pointer) == dsbmm_pkg::MAX_DELAY - 1) ?
                         '0 : frame_pointer + 1'b1;
      end
      if (sample_take && frame_end) begin
        issue_idx <= '0;
      end else if (walk_issue) begin
        issue_idx <= issue_idx + 1'b1;
      end
      s1_v <= walk_issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  // ---------------------------------------------------------------------------
  // Tap table: 32-entry memory, valid bits make unwritten entries read as zero
  // ---------------------------------------------------------------------------
  dsbmm_pkg::tap_t             tap_mem [dsbmm_pkg::MAX_TAPS];
  logic [dsbmm_pkg::MAX_TAPS-1:0] tap_valid;
  dsbmm_pkg::tap_t             tap_q;
  logic                        tap_vq;
  logic                        slot_ok;
  logic [dsbmm_pkg::TAP_AW-1:0] slot_a;
  dsbmm_pkg::tap_t             tap_wr;

  assign slot_ok = int'(tap_slot) < dsbmm_pkg::MAX_TAPS;
  assign slot_a  = dsbmm_pkg::TAP_AW'(tap_slot);
  assign tap_wr  = '{source: tap_source, ear: tap_ear, delay: tap_delay, gain: tap_gain};

  always_ff @(posedge clk) begin
    if (load_take && slot_ok) tap_mem[slot_a] <= tap_wr;
    tap_q  <= tap_mem[issue_idx[dsbmm_pkg::TAP_AW-1:0]];
    tap_vq <= tap_valid[issue_idx[dsbmm_pkg::TAP_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_valid <= '0;
    end else if (load_take && slot_ok) begin
      tap_valid[slot_a] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: tap entry -> history address (row = frame_pointer - delay, wrapped)
  // ---------------------------------------------------------------------------
  dsbmm_pkg::tap_t               tap_cur;
  logic [dsbmm_pkg::DC_W-1:0]    d_ext, fp_ext, row_ext;
  logic [dsbmm_pkg::HIST_AW-1:0] hist_raddr;
  logic                          src_ok;

  always_comb begin
    tap_cur = tap_vq ? tap_q : '0;
    d_ext   = dsbmm_pkg::DC_W'(tap_cur.delay);
    if (int'(d_ext) >= dsbmm_pkg::MAX_DELAY) d_ext = dsbmm_pkg::DC_W'(dsbmm_pkg::MAX_DELAY - 1);
    fp_ext  = dsbmm_pkg::DC_W'(frame_pointer);
    if (fp_ext >= d_ext) begin
      row_ext = fp_ext - d_ext;
    end else begin
      row_ext = fp_ext + dsbmm_pkg::DC_W'(dsbmm_pkg::MAX_DELAY) - d_ext;
    end
    src_ok     = int'(tap_cur.source) < dsbmm_pkg::MAX_CHANNELS;
    hist_raddr = {row_ext[dsbmm_pkg::FP_W-1:0], dsbmm_pkg::CH_W'(tap_cur.source)};
  end

  // ---------------------------------------------------------------------------
  // Sample history memory: one write and one registered read per cycle
  // ---------------------------------------------------------------------------
  logic [dsbmm_pkg::SAMPLE_W-1:0] hist_mem [dsbmm_pkg::HIST_DEPTH];
  logic signed [dsbmm_pkg::SAMPLE_W-1:0] hist_q;
  logic [dsbmm_pkg::GAIN_W-1:0]   s2_gain;
  logic                           s2_ear;
  logic                           s2_use;

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_q  <= hist_mem[hist_raddr];
    s2_gain <= tap_cur.gain;
    s2_ear  <= tap_cur.ear;
    s2_use  <= src_ok;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: multiply by unsigned Q2.14 gain
  // ---------------------------------------------------------------------------
  logic signed [dsbmm_pkg::PROD_W-1:0] hist_ext, gain_ext, prod_c, s3_prod;
  logic                                s3_ear;

  always_comb begin
    hist_ext = dsbmm_pkg::PROD_W'(hist_q);
    gain_ext = signed'(dsbmm_pkg::PROD_W'(s2_gain));
    prod_c   = s2_use ? hist_ext * gain_ext : '0;
  end

  always_ff @(posedge clk) begin
    s3_prod <= prod_c;
    s3_ear  <= s2_ear;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: truncate toward zero, accumulate into the ear sum
  // ---------------------------------------------------------------------------
  logic signed [dsbmm_pkg::PROD_W-1:0] biased, shifted;
  logic signed [dsbmm_pkg::SC_W-1:0]   scaled;
  logic signed [dsbmm_pkg::ACC_W-1:0]  acc_l, acc_r, scaled_ext;

  always_comb begin
    biased     = s3_prod[dsbmm_pkg::PROD_W-1] ? s3_prod + TRUNC_BIAS : s3_prod;
    shifted    = biased >>> dsbmm_pkg::GAIN_FRAC;
    scaled     = shifted[dsbmm_pkg::SC_W-1:0];
    scaled_ext = dsbmm_pkg::ACC_W'(scaled);
  end

  always_ff @(posedge clk) begin
    if (sample_take && frame_end) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (s3_v) begin
      if (dsbmm_pkg::ear_t'(s3_ear) == dsbmm_pkg::EAR_RIGHT) begin
        acc_r <= acc_r + scaled_ext;
      end else begin
        acc_l <= acc_l + scaled_ext;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Post: saturate each ear, floor of the average
  // ---------------------------------------------------------------------------
  logic signed [dsbmm_pkg::SAMPLE_W-1:0] ear_l, ear_r, mono_next;
  logic signed [dsbmm_pkg::SAMPLE_W:0]   ear_total;

  always_comb begin
    if (acc_l > SAT_HI) ear_l = SAT_HI[dsbmm_pkg::SAMPLE_W-1:0];
    else if (acc_l < SAT_LO) ear_l = SAT_LO[dsbmm_pkg::SAMPLE_W-1:0];
    else ear_l = acc_l[dsbmm_pkg::SAMPLE_W-1:0];
    if (acc_r > SAT_HI) ear_r = SAT_HI[dsbmm_pkg::SAMPLE_W-1:0];
    else if (acc_r < SAT_LO) ear_r = SAT_LO[dsbmm_pkg::SAMPLE_W-1:0];
    else ear_r = acc_r[dsbmm_pkg::SAMPLE_W-1:0];
    ear_total = (dsbmm_pkg::SAMPLE_W+1)'(ear_l) + (dsbmm_pkg::SAMPLE_W+1)'(ear_r);
    mono_next = ear_total[dsbmm_pkg::SAMPLE_W:1];
  end

  // output register: holds a result while the next samples come in
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (post) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) mono_sample <= mono_next;
  end

`ifndef NO_ASSERTIONS
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == dsbmm_pkg::ST_WALK) |-> !hist_we)
    else $error("history written during tap walk");

  a_post_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == dsbmm_pkg::ST_DONE))
    else $error("result posted outside done state");

  a_acc_in_walk: assert property (@(posedge clk) disable iff (rst)
    s3_v |-> (state == dsbmm_pkg::ST_WALK))
    else $error("accumulate outside tap walk");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == dsbmm_pkg::ST_WALK) |-> (issue_idx <= n_eff))
    else $error("tap index past tap count");
`endif

endmodule
